>>> rtl/itoa_pkg.sv
package itoa_pkg;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    TYPE_SDEC   = 3'd0,
    TYPE_UDEC   = 3'd1,
    TYPE_HEX32L = 3'd2,
    TYPE_HEX32U = 3'd3,
    TYPE_HEX64  = 3'd4
  } req_type_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_NEG,
    OP_DABBLE,
    OP_STRIP,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_HEX,
    COND_CNT,
    COND_STRIP,
    COND_NMORE
  } cond_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic start_ok;
    logic is_hex;
    logic cnt_more;
    logic strip_more;
    logic n_more;
  } status_t;

  localparam int NIBBLES       = 16;
  localparam int DIG_W         = 4 * NIBBLES;
  localparam int N_W           = $clog2(NIBBLES + 1);
  localparam int BCD_DIGITS    = 10;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int DABBLE_STEPS  = 32;
  localparam int CNT_W         = $clog2(DABBLE_STEPS + 1);

  localparam logic [6:0] CHAR_ZERO   = 7'h30;
  localparam logic [6:0] CHAR_LOWER  = 7'h61;
  localparam logic [6:0] CHAR_UPPER  = 7'h41;
  localparam logic [6:0] CHAR_MINUS  = 7'h2d;

  function automatic logic [6:0] nib_char(input logic [3:0] nib, input logic upper);
    logic [6:0] base;
    begin
      base = upper ? CHAR_UPPER : CHAR_LOWER;
      if (nib < 4'd10) begin
        nib_char = CHAR_ZERO + {3'b000, nib};
      end else begin
        nib_char = base + {3'b000, nib - 4'd10};
      end
    end
  endfunction

endpackage

>>> rtl/itoa_seq.sv
module itoa_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  itoa_pkg::status_t status,
  output itoa_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import itoa_pkg::*;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DISP   = 3'd1;
  localparam step_t STEP_NEG    = 3'd2;
  localparam step_t STEP_DABBLE = 3'd3;
  localparam step_t STEP_STRIP  = 3'd4;
  localparam step_t STEP_SIGN   = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;

  step_t pc_r, pc_nxt;
  logic  take;

  always_comb begin
    case (pc_r)
      STEP_IDLE:   ctrl = '{OP_LOAD,   COND_START,  STEP_DISP,   STEP_IDLE};
      STEP_DISP:   ctrl = '{OP_NOP,    COND_HEX,    STEP_STRIP,  STEP_NEG};
      STEP_NEG:    ctrl = '{OP_NEG,    COND_ALWAYS, STEP_DABBLE, STEP_DABBLE};
      STEP_DABBLE: ctrl = '{OP_DABBLE, COND_CNT,    STEP_DABBLE, STEP_STRIP};
      STEP_STRIP:  ctrl = '{OP_STRIP,  COND_STRIP,  STEP_STRIP,  STEP_SIGN};
      STEP_SIGN:   ctrl = '{OP_SIGN,   COND_ALWAYS, STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:   ctrl = '{OP_EMIT,   COND_NMORE,  STEP_EMIT,   STEP_IDLE};
      default:     ctrl = '{OP_NOP,    COND_ALWAYS, STEP_IDLE,   STEP_IDLE};
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS: take = 1'b1;
      COND_START:  take = status.start_ok;
      COND_HEX:    take = status.is_hex;
      COND_CNT:    take = status.cnt_more;
      COND_STRIP:  take = status.strip_more;
      COND_NMORE:  take = status.n_more;
      default:     take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.tgt_t : ctrl.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy = (pc_r != STEP_IDLE);

endmodule

>>> rtl/integer_to_ascii_converter_top.sv
// decimal items pass through negate, double-dabble, zero strip, sign and emit
// hex items skip negate and double-dabble; a new item is taken only while busy is low
// cost is set by the 32-step double-dabble loop and the one-nibble-per-cycle zero strip
// characters leave one per cycle, each strobed for one cycle; the receiver cannot stall
// an undefined format code is not accepted (the sequencer stays idle) and gives no characters
// synchronous active-low reset returns the sequencer to idle and clears the strobe
module integer_to_ascii_converter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::in_item_t  in_data,
  output logic                out_valid,
  output itoa_pkg::out_item_t out_data
);
  import itoa_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic [2:0]       type_r;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [31:0]      bin_r, bin_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       top_nib;

  itoa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  assign top_nib = dig_r[DIG_W-1 -: 4];

  always_comb begin
    status.start_ok   = start && (in_data.req_type inside {[TYPE_SDEC:TYPE_HEX64]});
    status.is_hex     = type_r inside {TYPE_HEX32L, TYPE_HEX32U, TYPE_HEX64};
    status.cnt_more   = (cnt_r != CNT_W'(1));
    status.strip_more = (top_nib == 4'd0) && (n_r > N_W'(1));
    status.n_more     = (n_r != N_W'(1));
  end

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (ctrl.op)
      OP_LOAD: begin
        neg_nxt = 1'b0;
        n_nxt   = N_W'(NIBBLES);
        bin_nxt = in_data.value[31:0];
        if (in_data.req_type == TYPE_HEX64) begin
          dig_nxt = in_data.value;
        end else begin
          dig_nxt = {32'd0, in_data.value[31:0]};
        end
      end
      OP_NEG: begin
        dig_nxt = '0;
        cnt_nxt = CNT_W'(DABBLE_STEPS);
        if (type_r == TYPE_SDEC && bin_r[31]) begin
          bin_nxt = 32'd0 - bin_r;
          neg_nxt = 1'b1;
        end
      end
      OP_DABBLE: begin
        dig_nxt = {{(DIG_W-BCD_W){1'b0}}, bcd_adj[BCD_W-2:0], bin_r[31]};
        bin_nxt = {bin_r[30:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_STRIP: begin
        if (status.strip_more) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          n_nxt   = n_r - N_W'(1);
        end
      end
      OP_SIGN: begin
        out_valid_nxt          = neg_r;
        out_data_nxt.char_code = CHAR_MINUS;
        out_data_nxt.last      = 1'b0;
      end
      OP_EMIT: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_code = nib_char(top_nib, type_r == TYPE_HEX32U);
        out_data_nxt.last      = (n_r == N_W'(1));
        dig_nxt                = {dig_r[DIG_W-5:0], 4'd0};
        n_nxt                  = n_r - N_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LOAD && start) begin
      type_r <= in_data.req_type;
    end
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/itoa_chk.sv
module itoa_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input itoa_pkg::in_item_t  in_data,
  input logic                out_valid,
  input itoa_pkg::out_item_t out_data
);
  import itoa_pkg::*;

  // a character that is not the last one leaves while the item is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-last character while idle");

  // the last character of an item is never directly followed by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("character right after last");

  // no character in the cycle after a transaction is accepted
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("character right after accept");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_code == CHAR_MINUS |-> !out_data.last)
    else $error("minus sign flagged last");

  // the item ends exactly with its last character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_data.last)
    else $error("item ended without last character");

endmodule

bind integer_to_ascii_converter_top itoa_chk u_chk (.*);
